// ===== rtl/afod_pkg.sv =====
package afod_pkg;

  // Field and register widths
  localparam int ENERGY_W   = 24;
  localparam int MEAN_W     = 32;
  localparam int MEAN_EXTRA = MEAN_W - ENERGY_W;
  localparam int HOP_W      = 11;
  localparam int SENS_W     = 9;
  localparam int COEFF_W    = 16;
  localparam int REFR_W     = 10;
  localparam int MULT_W     = 11;
  localparam int PROD_W     = MEAN_W + COEFF_W;
  localparam int CMP_W      = MEAN_W + MULT_W;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  // Register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_SENSITIVITY = 2'd0,
    REG_MEAN_COEFF  = 2'd1,
    REG_REFRACTORY  = 2'd2,
    REG_MIN_LEVEL   = 2'd3
  } reg_idx_t;

  // Reset values of the registers
  localparam logic [SENS_W-1:0]   SENS_RESET  = SENS_W'(128);
  localparam logic [COEFF_W-1:0]  COEFF_RESET = COEFF_W'(2048);
  localparam logic [REFR_W-1:0]   REFR_RESET  = REFR_W'(5);
  localparam logic [ENERGY_W-1:0] LEVEL_RESET = '0;

  // Sensitivity of 1.0 in Q1.8; larger codes act as this
  localparam logic [SENS_W-1:0] SENS_ONE  = SENS_W'(256);
  // Multiplier 1.5 + 6*(1 - s) in Q.8 is 1920 - 6*s
  localparam logic [MULT_W-1:0] MULT_BASE = MULT_W'(1920);

  // Threshold multiplier in Q.8 from a raw sensitivity code
  function automatic logic [MULT_W-1:0] mult_from_sens(input logic [SENS_W-1:0] sens);
    logic [SENS_W-1:0] s_sat;
    logic [MULT_W-1:0] six_s;
    s_sat = (sens > SENS_ONE) ? SENS_ONE : sens;
    six_s = MULT_W'({s_sat, 2'b00}) + MULT_W'({s_sat, 1'b0});
    return MULT_BASE - six_s;
  endfunction

endpackage

// ===== rtl/afod_mean_follower.sv =====
module afod_mean_follower (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [afod_pkg::ENERGY_W-1:0] flux,
  input  logic [afod_pkg::COEFF_W-1:0]  coeff,
  output logic [afod_pkg::MEAN_W-1:0]   mean
);
  import afod_pkg::*;

  logic [MEAN_W-1:0] flux_ext;
  logic              rising;
  logic [MEAN_W-1:0] diff;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] prod_up;
  logic [MEAN_W-1:0] mean_next;

  // Move the mean a coeff fraction of the way toward the new flux,
  // flooring on the way up and ceiling on the way down
  always_comb begin
    flux_ext  = {flux, {MEAN_EXTRA{1'b0}}};
    rising    = flux_ext >= mean;
    diff      = rising ? (flux_ext - mean) : (mean - flux_ext);
    prod      = PROD_W'(diff) * PROD_W'(coeff);
    prod_up   = prod + PROD_W'({COEFF_W{1'b1}});
    mean_next = rising ? (mean + prod[PROD_W-1:COEFF_W])
                       : (mean - prod_up[PROD_W-1:COEFF_W]);
  end

  // Hold the running mean between hops
  always_ff @(posedge clk) begin
    if (rst) begin
      mean <= '0;
    end else if (load) begin
      mean <= mean_next;
    end
  end

endmodule

// ===== rtl/adaptive_flux_onset_detector.sv =====
// Adaptive spectral-flux onset detector.
// Input stream: one band energy per hop on s_tdata (unsigned, 16 fractional
// bits), accepted when s_tvalid and s_tready are high. Output stream: one
// beat per input beat, in order, with the rectified rise on m_tdata and the
// onset flag on m_tuser.
// Configuration: APB port, sensitivity at 0x0, mean_coeff at 0x4,
// refractory_hops at 0x8, min_level at 0xC. Write only while the stream is
// idle. pready is tied high; reads return the stored register values.
// Path: a beat accepted into the input register goes on to the output
// register, where it shows on m_tvalid (threshold compare with the
// mean-times-multiplier product, the hop counter and the mean update side
// by side into the output register).
// Throughput: one beat per cycle while m_tready stays high; each state loop
// (previous energy, mean, hop counter) closes within a single stage.
// Stall: when m_tready is low the output beat holds, the input register takes
// one more beat, then s_tready drops.
// Reset: rst (synchronous) empties the pipeline, zeroes the previous energy
// and the mean, saturates the hop counter and restores register defaults.
module adaptive_flux_onset_detector (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [afod_pkg::ENERGY_W-1:0] s_tdata,   // [23:0] band_energy
  // Output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [afod_pkg::ENERGY_W-1:0] m_tdata,   // [23:0] flux_strength
  output logic                          m_tuser,   // [0] onset
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [afod_pkg::ADDR_W-1:0]   paddr,
  input  logic [afod_pkg::DATA_W-1:0]   pwdata,
  output logic [afod_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import afod_pkg::*;

  // Configuration registers
  logic [SENS_W-1:0]   sensitivity;
  logic [MULT_W-1:0]   mult_q8;
  logic [COEFF_W-1:0]  mean_coeff;
  logic [REFR_W-1:0]   refractory_hops;
  logic [ENERGY_W-1:0] min_level;
  logic                cfg_wr;
  reg_idx_t            cfg_idx;

  // Pipeline
  logic                a_valid;
  logic [ENERGY_W-1:0] a_energy;
  logic [ENERGY_W-1:0] a_flux;
  logic [ENERGY_W-1:0] previous_energy;
  logic [MEAN_W-1:0]   mean_flux;
  logic [HOP_W-1:0]    hop_cnt;

  logic                out_ready;
  logic                a_ready;
  logic                accept;
  logic                a_adv;

  logic [ENERGY_W-1:0] flux_in;
  logic [CMP_W-1:0]    lhs;
  logic [CMP_W-1:0]    rhs;
  logic [HOP_W-1:0]    hop_inc;
  logic [HOP_W-1:0]    hop_cnt_next;
  logic                loud;
  logic                clears;
  logic                hop_ready;
  logic                fire;

  // Decode register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sensitivity     <= SENS_RESET;
      mult_q8         <= mult_from_sens(SENS_RESET);
      mean_coeff      <= COEFF_RESET;
      refractory_hops <= REFR_RESET;
      min_level       <= LEVEL_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SENSITIVITY: begin
          sensitivity <= pwdata[SENS_W-1:0];
          mult_q8     <= mult_from_sens(pwdata[SENS_W-1:0]);
        end
        REG_MEAN_COEFF:  mean_coeff      <= pwdata[COEFF_W-1:0];
        REG_REFRACTORY:  refractory_hops <= pwdata[REFR_W-1:0];
        REG_MIN_LEVEL:   min_level       <= pwdata[ENERGY_W-1:0];
        default:         ;
      endcase
    end
  end

  // Return register contents on reads
  always_comb begin
    unique case (cfg_idx)
      REG_SENSITIVITY: prdata = DATA_W'(sensitivity);
      REG_MEAN_COEFF:  prdata = DATA_W'(mean_coeff);
      REG_REFRACTORY:  prdata = DATA_W'(refractory_hops);
      REG_MIN_LEVEL:   prdata = DATA_W'(min_level);
      default:         prdata = '0;
    endcase
  end

  // Advance a stage when the one after it is empty or moving
  assign out_ready = !m_tvalid || m_tready;
  assign a_ready   = !a_valid || out_ready;
  assign s_tready  = a_ready;
  assign accept    = s_tvalid && s_tready;
  assign a_adv     = a_valid && out_ready;

  // Input stage: rectified rise over the previous hop
  assign flux_in = (s_tdata > previous_energy) ? (s_tdata - previous_energy) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      previous_energy <= '0;
    end else begin
      if (accept) begin
        a_valid         <= 1'b1;
        previous_energy <= s_tdata;
      end else if (a_adv) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_energy <= s_tdata;
      a_flux   <= flux_in;
    end
  end

  // Mean follower: updates as the hop leaves, the compare sees the old mean
  afod_mean_follower u_mean (
    .clk   (clk),
    .rst   (rst),
    .load  (a_adv),
    .flux  (a_flux),
    .coeff (mean_coeff),
    .mean  (mean_flux)
  );

  // Threshold: compare against the old mean and gate by refractory and min_level
  always_comb begin
    lhs          = CMP_W'({a_flux, {MEAN_EXTRA{1'b0}}, 8'h00});
    rhs          = CMP_W'(mean_flux) * CMP_W'(mult_q8);
    hop_inc      = (hop_cnt != {HOP_W{1'b1}}) ? (hop_cnt + HOP_W'(1)) : hop_cnt;
    loud         = a_energy > min_level;
    clears       = (lhs > rhs) && (a_flux > min_level);
    hop_ready    = hop_inc >= HOP_W'(refractory_hops);
    fire         = loud && clears && hop_ready;
    hop_cnt_next = fire ? '0 : hop_inc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hop_cnt  <= {HOP_W{1'b1}};
      m_tvalid <= 1'b0;
    end else begin
      if (a_adv) begin
        hop_cnt  <= hop_cnt_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      m_tdata <= a_flux;
      m_tuser <= fire;
    end
  end

  // An onset always carries a nonzero rise
  a_onset_has_flux: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata != '0)
    else $error("onset reported with zero flux");

  // Reporting an onset restarts the refractory count
  a_fire_clears_count: assert property (@(posedge clk) disable iff (rst)
    a_adv && fire |=> hop_cnt == '0)
    else $error("hop counter not cleared after onset");

  // The stored multiplier stays in the 1.5 to 7.5 band
  a_mult_range: assert property (@(posedge clk) disable iff (rst)
    mult_q8 >= MULT_W'(384) && mult_q8 <= MULT_BASE)
    else $error("threshold multiplier out of range");

  // An empty output stage never blocks the input
  a_empty_takes: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // The updated mean lies between the old mean and the new flux
  a_mean_bounded: assert property (@(posedge clk) disable iff (rst)
    a_adv |=> (mean_flux >= $past(mean_flux)
               && mean_flux <= {$past(a_flux), {MEAN_EXTRA{1'b0}}})
           || (mean_flux <= $past(mean_flux)
               && mean_flux >= {$past(a_flux), {MEAN_EXTRA{1'b0}}}))
    else $error("mean update left its bounds");

endmodule

// ===== verif/adaptive_flux_onset_detector_tb.sv =====
module adaptive_flux_onset_detector_tb;
  import afod_pkg::*;

  localparam int LATENCY     = 1;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_HOPS  = 270;
  localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;
  localparam logic [SENS_W-1:0]   SENS_MAX   = '1;
  localparam logic [COEFF_W-1:0]  COEFF_MAX  = '1;
  localparam logic [REFR_W-1:0]   REFR_MAX   = '1;
  localparam logic [HOP_W-1:0]    HOP_SAT    = '1;

  typedef struct packed {
    logic                onset;
    logic [ENERGY_W-1:0] flux;
  } hop_result_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [ENERGY_W-1:0] s_tdata;   // [23:0] band_energy
  logic                m_tvalid;
  logic                m_tready;
  logic [ENERGY_W-1:0] m_tdata;   // [23:0] flux_strength
  logic                m_tuser;   // [0] onset
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predictor state and register copies
  logic [ENERGY_W-1:0] last_energy;
  logic [MEAN_W-1:0]   flux_mean;
  logic [HOP_W-1:0]    hop_count;
  logic [SENS_W-1:0]   sens_reg;
  logic [COEFF_W-1:0]  coeff_reg;
  logic [REFR_W-1:0]   refr_reg;
  logic [ENERGY_W-1:0] level_reg;

  hop_result_t pending_hops[$];
  int          error_count;
  int          hop_total;
  int          quiet_cycles;
  logic        no_idle;
  logic        hold_cmd;
  int          hold_left;
  logic [1:0]  rx_gap;

  adaptive_flux_onset_detector i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Work out the flux and onset flag of one hop and advance the state
  function automatic void predict_hop(input logic [ENERGY_W-1:0] energy);
    logic [ENERGY_W-1:0] flux;
    logic [SENS_W-1:0]   sens_sat;
    logic [63:0]         mult_q8, flux_ext, scaled_flux, mean_bound, mean_ext, diff;
    logic                loud, clears, ready, fire;
    flux = (energy > last_energy) ? energy - last_energy : '0;
    sens_sat = (sens_reg > SENS_ONE) ? SENS_ONE : sens_reg;
    mult_q8 = 64'd1920 - 64'd6 * 64'(sens_sat);
    flux_ext = 64'(flux) << MEAN_EXTRA;
    scaled_flux = flux_ext << 8;
    mean_ext = 64'(flux_mean);
    mean_bound = mean_ext * mult_q8;
    last_energy = energy;
    if (hop_count != HOP_SAT) hop_count = hop_count + 1'b1;
    loud = energy > level_reg;
    clears = (scaled_flux > mean_bound) && (flux > level_reg);
    ready = 64'(hop_count) >= 64'(refr_reg);
    // Follow the flux after the compare; round toward the old mean on the way up, toward the flux on the way down
    if (flux_ext >= mean_ext) begin
      diff = flux_ext - mean_ext;
      flux_mean = flux_mean + MEAN_W'((diff * 64'(coeff_reg)) >> 16);
    end else begin
      diff = mean_ext - flux_ext;
      flux_mean = flux_mean - MEAN_W'((diff * 64'(coeff_reg) + 64'd65535) >> 16);
    end
    fire = loud && clears && ready;
    if (fire) hop_count = '0;
    pending_hops.push_back('{onset: fire, flux: flux});
  endfunction

  // Compare each output beat with the oldest predicted hop
  always @(posedge clk) begin
    hop_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hops.size() == 0) begin
        $error("unexpected beat: flux_strength %0h, onset %0b", m_tdata, m_tuser);
        error_count++;
      end else begin
        want = pending_hops.pop_front();
        if (m_tuser !== want.onset) begin
          $error("onset mismatch: expected %0b, actual %0b", want.onset, m_tuser);
          error_count++;
        end
        if (m_tdata !== want.flux) begin
          $error("flux_strength mismatch: expected %0h, actual %0h", want.flux, m_tdata);
          error_count++;
        end
      end
    end
  end

  // Drive m_tready: random stall per beat, long hold-off on request
  always @(posedge clk) begin
    logic [1:0] draw;
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap <= '0;
      hold_left <= 0;
    end else if (hold_cmd) begin
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= (hold_left == 1);
    end else if (rx_gap != 0) begin
      rx_gap <= rx_gap - 1'b1;
      m_tready <= (rx_gap == 2'd1);
    end else if (m_tvalid && m_tready) begin
      draw = no_idle ? 2'd0 : 2'($urandom_range(0, 3));
      rx_gap <= draw;
      m_tready <= (draw == 2'd0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void reset_predictor();
    sens_reg = SENS_RESET;
    coeff_reg = COEFF_RESET;
    refr_reg = REFR_RESET;
    level_reg = LEVEL_RESET;
    last_energy = '0;
    flux_mean = '0;
    hop_count = HOP_SAT;
  endfunction

  // Offer one band energy and wait for the beat to be taken
  task automatic send_hop(input logic [ENERGY_W-1:0] energy);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= energy;
    do @(posedge clk); while (!s_tready);
    predict_hop(energy);
    hop_total++;
  endtask

  // Hold the input until every predicted hop has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // Setup then access cycle; the register takes the data at the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SENSITIVITY: sens_reg = value[SENS_W-1:0];
      REG_MEAN_COEFF:  coeff_reg = value[COEFF_W-1:0];
      REG_REFRACTORY:  refr_reg = value[REFR_W-1:0];
      REG_MIN_LEVEL:   level_reg = value[ENERGY_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [SENS_W-1:0] sens, input logic [COEFF_W-1:0] coeff,
                           input logic [REFR_W-1:0] refr, input logic [ENERGY_W-1:0] level);
    write_reg(REG_SENSITIVITY, DATA_W'(sens));
    write_reg(REG_MEAN_COEFF, DATA_W'(coeff));
    write_reg(REG_REFRACTORY, DATA_W'(refr));
    write_reg(REG_MIN_LEVEL, DATA_W'(level));
  endtask

  // Quiet floor with small ripple, a sharp attack, then a decaying tail
  task automatic send_note();
    int unsigned span, floor_e, peak, quiet_len, tail_len;
    logic [ENERGY_W-1:0] tail_e;
    span = $urandom_range(4, 23);
    floor_e = $urandom_range(0, (1 << span) - 1) >> 3;
    peak = floor_e + $urandom_range(1 << (span - 2), (1 << span) - 1);
    quiet_len = $urandom_range(2, 12);
    tail_len = $urandom_range(0, 6);
    repeat (quiet_len) send_hop(ENERGY_W'(floor_e + $urandom_range(0, (floor_e >> 4) + 1)));
    send_hop(ENERGY_W'(peak));
    tail_e = ENERGY_W'(peak);
    repeat (tail_len) begin
      tail_e = tail_e - (tail_e >> 2);
      send_hop(tail_e);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 7))
      0:       send_hop('0);
      1:       send_hop(ENERGY_MAX);
      default: send_hop(ENERGY_W'($urandom));
    endcase
  endtask

  // Mostly note shapes, some raw noise
  task automatic send_mix(input int count);
    int stop_at;
    stop_at = hop_total + count;
    while (hop_total < stop_at) begin
      if ($urandom_range(0, 99) < 15) send_noise();
      else send_note();
    end
  endtask

  // Pick a register setting, leaning on the extremes; junk above the field width
  task automatic randomize_regs();
    logic [DATA_W-1:0] junk;
    logic [SENS_W-1:0] sens;
    logic [COEFF_W-1:0] coeff;
    logic [REFR_W-1:0] refr;
    logic [ENERGY_W-1:0] level;
    case ($urandom_range(0, 5))
      0:       sens = '0;
      1:       sens = SENS_ONE;
      2:       sens = SENS_MAX;
      default: sens = SENS_W'($urandom_range(0, 511));
    endcase
    case ($urandom_range(0, 5))
      0:       coeff = '0;
      1:       coeff = COEFF_MAX;
      2:       coeff = COEFF_W'($urandom_range(256, 8192));
      default: coeff = COEFF_W'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0:       refr = '0;
      1:       refr = REFR_MAX;
      2:       refr = REFR_W'($urandom);
      default: refr = REFR_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(0, 6))
      0:       level = '0;
      1:       level = ENERGY_MAX;
      2:       level = ENERGY_W'($urandom);
      3:       level = ENERGY_W'($urandom_range(0, 'hFFFF));
      default: level = ENERGY_W'($urandom_range(0, 'hFFF));
    endcase
    junk = $urandom;
    write_reg(REG_SENSITIVITY, {junk[DATA_W-1:SENS_W], sens});
    junk = $urandom;
    write_reg(REG_MEAN_COEFF, {junk[DATA_W-1:COEFF_W], coeff});
    junk = $urandom;
    write_reg(REG_REFRACTORY, {junk[DATA_W-1:REFR_W], refr});
    junk = $urandom;
    write_reg(REG_MIN_LEVEL, {junk[DATA_W-1:ENERGY_W], level});
  endtask

  // Register defaults: silence, full-scale step, hold, fall, tiny rises, a half-scale rise, a small dip
  task automatic test_reset_defaults();
    send_hop('0);
    send_hop(ENERGY_MAX);
    send_hop(ENERGY_MAX);
    send_hop('0);
    send_hop(24'h000001);
    send_hop(24'h000100);
    send_hop(24'h800000);
    send_hop(24'h7FFFFF);
  endtask

  // Register extremes: frozen mean, zero refractory, floor at full scale,
  // saturated sensitivity, energy and rise just at the floor
  task automatic test_register_extremes();
    wait_drained();
    write_all('0, '0, '0, '0);
    send_hop(24'h000010);
    send_hop(24'h000020);
    send_hop(24'h000040);
    send_hop(24'h000041);
    wait_drained();
    write_all(SENS_MAX, COEFF_MAX, REFR_MAX, ENERGY_MAX);
    send_hop('0);
    send_hop(ENERGY_MAX);
    wait_drained();
    write_all(SENS_ONE, COEFF_RESET, REFR_W'(1), ENERGY_W'(24'h000100));
    send_hop('0);
    send_hop(24'h000100);
    send_hop('0);
    send_hop(24'h000201);
    send_hop(24'h000402);
  endtask

  // Hold the output off long enough to fill the pipe and stall the input
  task automatic test_output_hold();
    wait_drained();
    write_all(SENS_RESET, COEFF_RESET, REFR_W'(3), LEVEL_RESET);
    hold_cmd <= 1'b1;
    no_idle <= 1'b1;
    @(posedge clk);
    hold_cmd <= 1'b0;
    repeat (4) send_note();
    no_idle <= 1'b0;
  endtask

  // Pause the input until every result is out, then resume
  task automatic test_input_pause();
    send_mix(30);
    wait_drained();
    send_mix(30);
  endtask

  // Several random settings, one phase without idle cycles
  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      randomize_regs();
      no_idle <= (phase == 2);
      send_mix(PHASE_HOPS);
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_cmd = 1'b0;
    no_idle = 1'b0;
    error_count = 0;
    hop_total = 0;
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_output_hold();
    test_input_pause();
    test_random_settings();

    wait_drained();
    repeat (4 * LATENCY) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
